// File: rtl/mts_pkg.sv
package mts_pkg;

	// Input event
	typedef struct packed {
		logic [4:0]         command;
		logic [9:0]         event_code;
		logic signed [31:0] event_value;
	} evt_t;

	// Reported point
	typedef struct packed {
		logic        point_valid;
		logic [15:0] point_id;
		logic [15:0] point_x;
		logic [15:0] point_y;
		logic [31:0] point_time;
		logic [3:0]  point_index;
		logic        last_point;
	} pnt_t;

	// Register indexes
	localparam logic [2:0] CFG_GRID_X_MIN  = 3'd0;
	localparam logic [2:0] CFG_GRID_X_MAX  = 3'd1;
	localparam logic [2:0] CFG_GRID_Y_MIN  = 3'd2;
	localparam logic [2:0] CFG_GRID_Y_MAX  = 3'd3;
	localparam logic [2:0] CFG_WIN_WIDTH   = 3'd4;
	localparam logic [2:0] CFG_WIN_HEIGHT  = 3'd5;

	// Event types
	localparam logic [4:0] CMD_SYN = 5'd0;
	localparam logic [4:0] CMD_KEY = 5'd1;
	localparam logic [4:0] CMD_ABS = 5'd3;
	localparam logic [4:0] CMD_MSC = 5'd4;

	// Event codes
	localparam logic [9:0] SYN_FRAME    = 10'd0;
	localparam logic [9:0] ABS_X        = 10'd0;
	localparam logic [9:0] ABS_Y        = 10'd1;
	localparam logic [9:0] ABS_SLOT_SEL = 10'd47;
	localparam logic [9:0] ABS_MT_X     = 10'd53;
	localparam logic [9:0] ABS_MT_Y     = 10'd54;
	localparam logic [9:0] ABS_MT_TRK   = 10'd57;
	localparam logic [9:0] MSC_STAMP    = 10'd5;
	localparam logic [9:0] KEY_CONTACT  = 10'd330;

	localparam logic [3:0] LAST_INDEX = 4'hF;

endpackage

// File: rtl/multitouch_slot_tracker_unit.sv
// Sequence: a frame-end report with an empty result goes straight to the output load;
// otherwise each point takes a slot read, two scale passes (x then y) through the shared
// serial divider and an output load; a pass that saturates or sees a non-positive grid
// range skips the divide steps.
// Throughput: one event at a time; evt_stall is high while a report is being walked.
// Reset: arst_n clears the slot select plus tracking, ready and valid bits, loads register
// defaults; slot memories are not cleared, valid bits mask positions and stamps to zero.
module multitouch_slot_tracker_unit #(
	parameter int TOUCH_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_stall,
	input  mts_pkg::evt_t evt,
	output logic          pnt_valid,
	input  logic          pnt_stall,
	output mts_pkg::pnt_t pnt,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import mts_pkg::*;

	localparam int SW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_XCAL = 3'd2;
	localparam logic [2:0] ST_YCAL = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] st_q;

	// Registers
	logic signed [15:0] gx_min_q, gx_max_q, gy_min_q, gy_max_q;
	logic [13:0]        win_w_q, win_h_q;

	// Slot memories (x in the upper half, y in the lower; id above the stamp)
	logic [31:0] mem_pos [TOUCH_SLOTS];
	logic [47:0] mem_tag [TOUCH_SLOTS];
	logic [TOUCH_SLOTS-1:0] xv_q, yv_q, tv_q, trk_q, rdy_q;

	logic [SW-1:0] act_q;
	logic          act_ok_q, changed_q, contact_q;

	logic [TOUCH_SLOTS-1:0] mask_q, mask_nxt;
	logic [SW-1:0]          pick;
	logic [3:0]             cnt_q;
	logic                   last_q, go_q;
	logic [15:0]            rd_x_q, rd_y_q, rd_id_q, res_x_q;
	logic [31:0]            rd_ts_q;
	pnt_t                   res_q, pnt_q;
	logic                   pnt_valid_q;

	logic        acc, out_free;
	logic        sc_done;
	logic [15:0] sc_quo;
	logic        ycal;

	assign acc       = evt_valid && !evt_stall;
	assign evt_stall = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !pnt_valid_q || !pnt_stall;
	assign pnt_valid = pnt_valid_q;
	assign pnt       = pnt_q;
	assign ycal      = (st_q == ST_YCAL);

	// Lowest pending slot
	always_comb begin
		pick = '0;
		for (int i = TOUCH_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) pick = SW'(i);
		end
		mask_nxt       = mask_q;
		mask_nxt[pick] = 1'b0;
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_min_q <= 16'sd0;
			gx_max_q <= 16'sd4095;
			gy_min_q <= 16'sd0;
			gy_max_q <= 16'sd4095;
			win_w_q  <= 14'd800;
			win_h_q  <= 14'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_X_MIN: gx_min_q <= cfg_data;
				CFG_GRID_X_MAX: gx_max_q <= cfg_data;
				CFG_GRID_Y_MIN: gy_min_q <= cfg_data;
				CFG_GRID_Y_MAX: gy_max_q <= cfg_data;
				CFG_WIN_WIDTH:  win_w_q  <= cfg_data[13:0];
				CFG_WIN_HEIGHT: win_h_q  <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Slot memory writes and reads
	always_ff @(posedge clk) begin
		if (acc && act_ok_q && evt.command == CMD_ABS && evt.event_value > 32'sd0) begin
			if (evt.event_code == ABS_X || evt.event_code == ABS_MT_X)
				mem_pos[act_q][31:16] <= (evt.event_value > 32'sd65535) ? 16'hFFFF
				                                                         : evt.event_value[15:0];
			if (evt.event_code == ABS_Y || evt.event_code == ABS_MT_Y)
				mem_pos[act_q][15:0] <= (evt.event_value > 32'sd65535) ? 16'hFFFF
				                                                        : evt.event_value[15:0];
		end
		if (acc && act_ok_q && evt.command == CMD_ABS && evt.event_code == ABS_MT_TRK)
			mem_tag[act_q][47:32] <= evt.event_value[15:0];
		if (acc && act_ok_q && evt.command == CMD_MSC && evt.event_code == MSC_STAMP)
			mem_tag[act_q][31:0] <= evt.event_value;
		if (st_q == ST_SCAN) begin
			rd_x_q  <= xv_q[pick] ? mem_pos[pick][31:16] : '0;
			rd_y_q  <= yv_q[pick] ? mem_pos[pick][15:0] : '0;
			rd_ts_q <= tv_q[pick] ? mem_tag[pick][31:0] : '0;
			rd_id_q <= mem_tag[pick][47:32];
		end
	end

	// Event handling and report sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			xv_q        <= '0;
			yv_q        <= '0;
			tv_q        <= '0;
			trk_q       <= '0;
			rdy_q       <= '0;
			act_q       <= '0;
			act_ok_q    <= 1'b1;
			changed_q   <= 1'b0;
			contact_q   <= 1'b0;
			go_q        <= 1'b0;
			pnt_valid_q <= 1'b0;
			mask_q      <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (pnt_valid_q && !pnt_stall) pnt_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						case (evt.command)
							CMD_SYN: begin
								if (evt.event_code == SYN_FRAME && changed_q) begin
									changed_q <= 1'b0;
									cnt_q     <= '0;
									mask_q    <= contact_q ? (trk_q & rdy_q) : '0;
									if (!contact_q || (trk_q & rdy_q) == '0)
										st_q <= ST_EMIT;
									else
										st_q <= ST_SCAN;
								end
							end
							CMD_KEY: begin
								if (evt.event_code == KEY_CONTACT) begin
									if (evt.event_value == 32'sd1) begin
										contact_q <= 1'b1;
									end else if (contact_q) begin
										trk_q     <= '0;
										rdy_q     <= '0;
										changed_q <= 1'b1;
										contact_q <= 1'b0;
									end
								end
							end
							CMD_ABS: begin
								if ((evt.event_code == ABS_X || evt.event_code == ABS_MT_X) &&
								    evt.event_value > 32'sd0 && act_ok_q) begin
									xv_q[act_q]  <= 1'b1;
									rdy_q[act_q] <= 1'b0;
									changed_q    <= 1'b1;
								end
								if ((evt.event_code == ABS_Y || evt.event_code == ABS_MT_Y) &&
								    evt.event_value > 32'sd0 && act_ok_q) begin
									yv_q[act_q]  <= 1'b1;
									rdy_q[act_q] <= 1'b0;
									changed_q    <= 1'b1;
								end
								if (evt.event_code == ABS_SLOT_SEL) begin
									if (evt.event_value == -32'sd1) begin
										if (act_ok_q) begin
											trk_q[act_q] <= 1'b0;
											rdy_q[act_q] <= 1'b0;
											changed_q    <= 1'b1;
										end
										act_q    <= '0;
										act_ok_q <= 1'b1;
									end else begin
										if (act_ok_q) rdy_q[act_q] <= 1'b1;
										if (evt.event_value >= 32'sd0 &&
										    evt.event_value < TOUCH_SLOTS) begin
											act_q    <= evt.event_value[SW-1:0];
											act_ok_q <= 1'b1;
										end else begin
											act_q    <= '0;
											act_ok_q <= 1'b0;
										end
									end
								end
								if (evt.event_code == ABS_MT_TRK && act_ok_q) begin
									trk_q[act_q] <= (evt.event_value != -32'sd1);
									changed_q    <= 1'b1;
								end
							end
							CMD_MSC: begin
								if (evt.event_code == MSC_STAMP && act_ok_q)
									tv_q[act_q] <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					mask_q <= mask_nxt;
					last_q <= (mask_nxt == '0) || (cnt_q == LAST_INDEX);
					go_q   <= 1'b1;
					st_q   <= ST_XCAL;
				end
				ST_XCAL: begin
					if (sc_done) begin
						go_q <= 1'b1;
						st_q <= ST_YCAL;
					end
				end
				ST_YCAL: begin
					if (sc_done) st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						pnt_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 4'd1;
						st_q        <= (res_q.last_point) ? ST_IDLE : ST_SCAN;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Result assembly and output register
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) res_q <= '{last_point: 1'b1, default: '0};
		if (st_q == ST_XCAL && sc_done) res_x_q <= sc_quo;
		if (st_q == ST_YCAL && sc_done) begin
			res_q.point_valid <= 1'b1;
			res_q.point_id    <= rd_id_q;
			res_q.point_x     <= res_x_q;
			res_q.point_y     <= sc_quo;
			res_q.point_time  <= rd_ts_q;
			res_q.point_index <= cnt_q;
			res_q.last_point  <= last_q;
		end
		if (st_q == ST_EMIT && out_free) pnt_q <= res_q;
	end

	mts_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.pos    (ycal ? rd_y_q : rd_x_q),
		.win    (ycal ? win_h_q : win_w_q),
		.lo     (ycal ? gy_min_q : gx_min_q),
		.hi     (ycal ? gy_max_q : gx_max_q),
		.done   (sc_done),
		.quo    (sc_quo)
	);

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && !pnt.point_valid |-> pnt.last_point)
		else $error("empty report not marked last");
	a_index_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && pnt.point_index == LAST_INDEX |-> pnt.last_point)
		else $error("sixteenth point not marked last");
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> (st_q == ST_XCAL || st_q == ST_YCAL))
		else $error("scale result outside a calculation state");
`endif

endmodule

// File: rtl/mts_scale.sv
module mts_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        pos,
	input  logic [13:0]        win,
	input  logic signed [15:0] lo,
	input  logic signed [15:0] hi,
	output logic               done,
	output logic [15:0]        quo
);
	import mts_pkg::*;

	localparam logic [1:0] SC_IDLE = 2'd0;
	localparam logic [1:0] SC_CHK  = 2'd1;
	localparam logic [1:0] SC_DIV  = 2'd2;

	logic [1:0]         st_q;
	logic [29:0]        prod_q;
	logic signed [16:0] range_q;
	logic [15:0]        rem_q;
	logic [3:0]         bit_q;
	logic [16:0]        rem_sh;
	logic               fits;

	// One restoring step: shift in the next product bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, prod_q[bit_q]};
		fits   = rem_sh >= {1'b0, range_q[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SC_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				SC_IDLE: begin
					if (start) st_q <= SC_CHK;
				end
				SC_CHK: begin
					if (range_q <= 17'sd0 || prod_q[29:16] >= range_q[15:0]) begin
						st_q <= SC_IDLE;
						done <= 1'b1;
					end else begin
						st_q <= SC_DIV;
					end
				end
				SC_DIV: begin
					if (bit_q == 4'd0) begin
						st_q <= SC_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= SC_IDLE;
			endcase
		end
	end

	// Product, range and quotient datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			SC_IDLE: begin
				if (start) begin
					prod_q  <= pos * win;
					range_q <= 17'(hi) - 17'(lo);
				end
			end
			SC_CHK: begin
				if (range_q <= 17'sd0) begin
					quo <= '0;
				end else if (prod_q[29:16] >= range_q[15:0]) begin
					quo <= 16'hFFFF;
				end else begin
					rem_q <= {2'b0, prod_q[29:16]};
					bit_q <= 4'd15;
					quo   <= '0;
				end
			end
			SC_DIV: begin
				rem_q <= fits ? 16'(rem_sh - {1'b0, range_q[15:0]}) : rem_sh[15:0];
				quo   <= {quo[14:0], fits};
				bit_q <= bit_q - 4'd1;
			end
			default: ;
		endcase
	end

endmodule
